// ----- rtl/core/fisr_pkg.sv -----
// ----------------------------------------------------------------------------
// fisr_pkg
// Shared constants and float helpers for the inverse square root pipeline.
// ----------------------------------------------------------------------------
package fisr_pkg;

   localparam logic [31:0] MAGIC_SEED  = 32'h5f375a86;
   localparam logic [31:0] HALF_BITS   = 32'h3f000000;
   localparam logic [31:0] THREEHALVES = 32'h3fc00000;
   localparam logic [31:0] QNAN_BITS   = 32'h7fc00000;
   localparam logic [31:0] INF_BITS    = 32'h7f800000;

   // special-case class of one float operation
   typedef struct packed {
      logic        special;
      logic [31:0] bits;
   } spec_type;

   function automatic logic is_nan(input logic [31:0] b);
      return b[30:0] > INF_BITS[30:0];
   endfunction

   function automatic logic is_inf(input logic [31:0] b);
      return b[30:0] == INF_BITS[30:0];
   endfunction

   function automatic logic is_zero(input logic [31:0] b);
      return b[30:0] == 31'd0;
   endfunction

   // significand with hidden bit; subnormals use biased exponent 1
   function automatic logic [23:0] sig_of(input logic [31:0] b);
      return {(b[30:23] != 8'd0), b[22:0]};
   endfunction

   function automatic logic [9:0] exp_of(input logic [31:0] b);
      return (b[30:23] == 8'd0) ? 10'd1 : {2'b00, b[30:23]};
   endfunction

endpackage

// ----- rtl/core/fisr_if.sv -----
// ----------------------------------------------------------------------------
// fisr_if
// Valid/ready channel carrying one 32-bit word.
// ----------------------------------------------------------------------------
interface fisr_if;
   logic        valid;
   logic        ready;
   logic [31:0] bits;

   modport source (output valid, output bits, input ready);
   modport sink (input valid, input bits, output ready);
endinterface

// ----- rtl/core/fisr_round.sv -----
// ----------------------------------------------------------------------------
// fisr_round
// Normalize and round a positive significand to binary32, nearest-even.
// Value is sig * 2^(exp - 127 - 47): sig has its unit at bit 47 when exp is
// the biased exponent. Bit 0 of sig may be sticky.
// ----------------------------------------------------------------------------
module fisr_round (
   input  logic               sign,
   input  logic signed [11:0] exp,
   input  logic [49:0]        sig,
   output logic [31:0]        bits
);

   localparam logic [30:0] INF_C = fisr_pkg::INF_BITS[30:0];

   logic [5:0]         lz;
   logic [49:0]        norm;
   logic signed [11:0] e;
   logic [11:0]        shr;
   logic [49:0]        den;
   logic               stk;
   logic [24:0]        m;
   logic               rnd;
   logic [31:0]        sum;
   logic               found;

   // leading one search, value scaled so bit 49 is leading
   always_comb begin
      lz    = 6'd0;
      found = 1'b0;
      for (int i = 49; i >= 0; i--) begin
         if (!found && sig[i]) begin
            lz    = 6'(49 - i);
            found = 1'b1;
         end
      end
      norm = sig << lz;
      // unit at bit 47 -> leading at 49 means exponent +2
      e    = exp + 12'sd2 - 12'(signed'({6'd0, lz}));
      if (e >= 12'sd1) shr = 12'd0;
      else shr = 12'(12'sd1 - e);
      if (shr > 12'd40) begin
         den = 50'd0;
         stk = (norm != 50'd0);
      end else begin
         den = norm >> shr[5:0];
         stk = ((norm & ((50'd1 << shr[5:0]) - 50'd1)) != 50'd0);
      end
      // keep 24 bits at [49:26], guard at 25, sticky below
      m   = {1'b0, den[49:26]};
      rnd = den[25] && ((den[24:0] != 25'd0) || stk || den[26]);
      sum = {1'b0, ((e >= 12'sd1) ? e[7:0] - 8'd1 : 8'd0), 23'd0} + 32'(m) + 32'(rnd);
      if (sum[30:0] > INF_C) sum[30:0] = INF_C;
      if (e > 12'sd254) begin
         bits = {sign, INF_C};
      end else begin
         bits = {sign, sum[30:0]};
      end
   end

endmodule

// ----- rtl/core/fisr_fmul.sv -----
// ----------------------------------------------------------------------------
// fisr_fmul
// Two-stage binary32 multiplier: product register, then round register.
// ----------------------------------------------------------------------------
module fisr_fmul (
   input  logic        clock,
   input  logic        enable,
   input  logic [31:0] a,
   input  logic [31:0] b,
   input  logic [31:0] a_pass,
   output logic [31:0] a_pass_out,
   output logic [31:0] result
);

   fisr_pkg::spec_type spec_ff, spec_in;
   logic               sign_ff;
   logic signed [11:0] exp_ff;
   logic [47:0]        prod_ff;
   logic [31:0]        pass_ff, pass2_ff, res_ff;
   logic [31:0]        rnd_bits;

   always_comb begin
      spec_in.special = 1'b1;
      spec_in.bits    = {a[31] ^ b[31], 31'd0};
      if (fisr_pkg::is_nan(a) || fisr_pkg::is_nan(b)) begin
         spec_in.bits = fisr_pkg::QNAN_BITS;
      end else if (fisr_pkg::is_inf(a) || fisr_pkg::is_inf(b)) begin
         if (fisr_pkg::is_zero(a) || fisr_pkg::is_zero(b)) spec_in.bits = fisr_pkg::QNAN_BITS;
         else spec_in.bits = {a[31] ^ b[31], fisr_pkg::INF_BITS[30:0]};
      end else if (!(fisr_pkg::is_zero(a) || fisr_pkg::is_zero(b))) begin
         spec_in.special = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         spec_ff  <= spec_in;
         sign_ff  <= a[31] ^ b[31];
         // product unit at bit 46, shifted up one on the way into the rounder
         exp_ff   <= 12'(signed'({2'b00, fisr_pkg::exp_of(a)}))
                   + 12'(signed'({2'b00, fisr_pkg::exp_of(b)})) - 12'sd127;
         prod_ff  <= fisr_pkg::sig_of(a) * fisr_pkg::sig_of(b);
         pass_ff  <= a_pass;
         res_ff   <= spec_ff.special ? spec_ff.bits : rnd_bits;
         pass2_ff <= pass_ff;
      end
   end

   fisr_round u_round (
      .sign (sign_ff),
      .exp  (exp_ff),
      .sig  ({1'b0, prod_ff, 1'b0}),
      .bits (rnd_bits)
   );

   assign result     = res_ff;
   assign a_pass_out = pass2_ff;

endmodule

// ----- rtl/core/fast_inverse_square_root.sv -----
// ----------------------------------------------------------------------------
// fast_inverse_square_root
// One-Newton-step inverse square root estimate on binary32 words.
// ----------------------------------------------------------------------------
// Takes one word per cycle and returns one word per cycle while the output is
// not stalled. From acceptance to the output register the pipe is four
// multipliers of two stages each, an adder of two stages, and the output register. The whole
// pipe advances together whenever the output register is empty or being
// taken, so backpressure stalls every stage at once and nothing is lost.
module fast_inverse_square_root (
   input logic     clock,
   input logic     reset,
   fisr_if.sink    req,
   fisr_if.source  rsp
);

   localparam int DEPTH = 11;

   logic [DEPTH-1:0] vld_ff;
   logic             adv;
   logic [31:0]      y0, h, y0_a, p, y0_b, q, y0_c, t, r;
   logic [31:0]      y0_t1_ff, y0_t2_ff, out_ff;
   logic [31:0]      rnd_bits, nb;
   // adder stage one registers
   fisr_pkg::spec_type aspec_ff, aspec_in;
   logic               asign_ff;
   logic signed [11:0] aexp_ff;
   logic [49:0]        asig_ff;
   logic [31:0]        t_ff;
   logic               asign_in;
   logic signed [11:0] aexp_in;
   logic [49:0]        asig_in;

   assign adv       = !rsp.valid || rsp.ready;
   assign req.ready = adv;
   assign rsp.valid = vld_ff[DEPTH-1];
   assign rsp.bits  = out_ff;
   assign y0        = fisr_pkg::MAGIC_SEED - {1'b0, req.bits[31:1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req.valid};
      end
   end

   fisr_fmul u_mul_h (.clock(clock), .enable(adv), .a(fisr_pkg::HALF_BITS),
      .b(req.bits), .a_pass(y0), .a_pass_out(y0_a), .result(h));
   fisr_fmul u_mul_p (.clock(clock), .enable(adv), .a(h), .b(y0_a),
      .a_pass(y0_a), .a_pass_out(y0_b), .result(p));
   fisr_fmul u_mul_q (.clock(clock), .enable(adv), .a(p), .b(y0_b),
      .a_pass(y0_b), .a_pass_out(y0_c), .result(q));

   // 1.5 - q : align and add/subtract, then round
   always_comb begin
      logic [31:0]        b;
      logic [9:0]         ea, eb, d;
      logic [49:0]        ma, mb, lost;
      logic               sa, sb;
      b  = {~q[31], q[30:0]};
      ea = fisr_pkg::exp_of(fisr_pkg::THREEHALVES);
      eb = fisr_pkg::exp_of(b);
      sa = 1'b0;
      sb = b[31];
      aspec_in.special = 1'b1;
      aspec_in.bits    = fisr_pkg::THREEHALVES;
      ma = 50'd0;
      mb = 50'd0;
      d  = 10'd0;
      lost = 50'd0;
      if (fisr_pkg::is_nan(b)) begin
         aspec_in.bits = fisr_pkg::QNAN_BITS;
      end else if (fisr_pkg::is_inf(b)) begin
         aspec_in.bits = b;
      end else if (!fisr_pkg::is_zero(b)) begin
         aspec_in.special = 1'b0;
      end
      asign_in = sa;
      aexp_in  = 12'(signed'({2'b00, ea}));
      asig_in  = 50'd0;
      if (ea >= eb) begin
         ma = {2'b0, fisr_pkg::sig_of(fisr_pkg::THREEHALVES), 24'd0};
         mb = {2'b0, fisr_pkg::sig_of(b), 24'd0};
         d  = ea - eb;
      end else begin
         ma = {2'b0, fisr_pkg::sig_of(b), 24'd0};
         mb = {2'b0, fisr_pkg::sig_of(fisr_pkg::THREEHALVES), 24'd0};
         d  = eb - ea;
         aexp_in = 12'(signed'({2'b00, eb}));
         sa = sb;
         sb = 1'b0;
      end
      if (d >= 10'd48) begin
         mb = 50'd1;
      end else if (d != 10'd0) begin
         lost = mb & ((50'd1 << d[5:0]) - 50'd1);
         mb   = (mb >> d[5:0]) | 50'(lost != 50'd0);
      end
      if (sa == sb) begin
         asig_in  = ma + mb;
         asign_in = sa;
      end else if (ma == mb) begin
         aspec_in.special = 1'b1;
         aspec_in.bits    = 32'd0;
      end else if (ma > mb) begin
         asig_in  = ma - mb;
         asign_in = sa;
      end else begin
         asig_in  = mb - ma;
         asign_in = sb;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         aspec_ff <= aspec_in;
         asign_ff <= asign_in;
         // sig unit at bit 47; value = sig*2^(exp-127-47)
         aexp_ff  <= aexp_in;
         asig_ff  <= asig_in;
         y0_t1_ff <= y0_c;
         t_ff     <= aspec_ff.special ? aspec_ff.bits : rnd_bits;
         y0_t2_ff <= y0_t1_ff;
         out_ff   <= fisr_pkg::is_nan(r) ? fisr_pkg::QNAN_BITS : r;
      end
   end

   fisr_round u_add_round (.sign(asign_ff), .exp(aexp_ff), .sig(asig_ff), .bits(rnd_bits));

   assign t = t_ff;

   fisr_fmul u_mul_r (.clock(clock), .enable(adv), .a(y0_t2_ff), .b(t),
      .a_pass(y0_t2_ff), .a_pass_out(nb), .result(r));

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives raw binary32 words through the inverse square root pipeline and
// checks every result against a typed-in value or an integer-only float predictor.
// ----------------------------------------------------------------------------
module testbench;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fisr_if req_ch ();
   fisr_if rsp_ch ();

   fast_inverse_square_root dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   localparam int RANDOM_WORDS = 1300;

   typedef struct {
      logic [31:0] x;
      logic        known;
      logic [31:0] r;
   } stim_type;

   logic [31:0] expected_words[$];
   int          error_count = 0;
   int          words_sent = 0;
   int          words_checked = 0;
   int          send_idle_pct = 0;
   int          take_idle_pct = 0;

   // ------------------------------------------------------------------------
   // float predictor (integer arithmetic)
   // ------------------------------------------------------------------------
   function automatic logic f_nan(logic [31:0] b);
      return b[30:0] > 31'h7f800000;
   endfunction

   function automatic logic f_inf(logic [31:0] b);
      return b[30:0] == 31'h7f800000;
   endfunction

   function automatic logic f_zero(logic [31:0] b);
      return b[30:0] == 31'd0;
   endfunction

   function automatic void split(logic [31:0] b, output logic [63:0] s,
                                 output int e);
      if (b[30:23] == 8'd0) begin
         s = {41'd0, b[22:0]};
         e = -149;
      end else begin
         s = {40'd0, 1'b1, b[22:0]};
         e = int'(b[30:23]) - 150;
      end
   endfunction

   function automatic logic [31:0] round_to_float(logic sign, int e_in,
                                                  logic [63:0] s_in);
      logic [63:0] s, m, rem, half;
      int          e, ex, sh;
      logic [31:0] base, b;
      s = s_in;
      e = e_in;
      while (s[62] == 1'b0) begin
         s = s << 1;
         e = e - 1;
      end
      ex = e + 62 + 127;
      if (ex > 254) return {sign, 31'h7f800000};
      if (ex >= 1) begin
         sh = 39;
         base = 32'(ex - 1) << 23;
      end else begin
         sh = 39 + (1 - ex);
         base = 32'd0;
         if (sh > 63) return {sign, 31'd0};
      end
      m = s >> sh;
      rem = s & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && m[0])) m = m + 64'd1;
      b = base + m[31:0];
      if (b > fisr_pkg::INF_BITS) b = fisr_pkg::INF_BITS;
      return {sign, b[30:0]};
   endfunction

   function automatic logic [31:0] float_mul(logic [31:0] a, logic [31:0] b);
      logic        sign;
      logic [63:0] sa, sb;
      int          ea, eb;
      sign = a[31] ^ b[31];
      if (f_nan(a) || f_nan(b)) return fisr_pkg::QNAN_BITS;
      if (f_inf(a) || f_inf(b)) begin
         if (f_zero(a) || f_zero(b)) return fisr_pkg::QNAN_BITS;
         return {sign, 31'h7f800000};
      end
      if (f_zero(a) || f_zero(b)) return {sign, 31'd0};
      split(a, sa, ea);
      split(b, sb, eb);
      return round_to_float(sign, ea + eb, sa * sb);
   endfunction

   function automatic logic [31:0] float_add(logic [31:0] a, logic [31:0] b);
      logic        sa, sb, ts;
      logic [63:0] ma, mb, tm, lost;
      int          ea, eb, te, d;
      sa = a[31];
      sb = b[31];
      if (f_nan(a) || f_nan(b)) return fisr_pkg::QNAN_BITS;
      if (f_inf(a) && f_inf(b)) return (sa == sb) ? a : fisr_pkg::QNAN_BITS;
      if (f_inf(a)) return a;
      if (f_inf(b)) return b;
      if (f_zero(a) && f_zero(b)) return {sa & sb, 31'd0};
      if (f_zero(a)) return b;
      if (f_zero(b)) return a;
      split(a, ma, ea);
      split(b, mb, eb);
      if (ea < eb) begin
         ts = sa; sa = sb; sb = ts;
         tm = ma; ma = mb; mb = tm;
         te = ea; ea = eb; eb = te;
      end
      ma = ma << 38;
      mb = mb << 38;
      d = ea - eb;
      if (d >= 62) mb = 64'd1;
      else if (d > 0) begin
         lost = mb & ((64'd1 << d) - 64'd1);
         mb = (mb >> d) | {63'd0, lost != 64'd0};
      end
      if (sa == sb) return round_to_float(sa, ea - 38, ma + mb);
      if (ma == mb) return 32'd0;
      if (ma > mb) return round_to_float(sa, ea - 38, ma - mb);
      return round_to_float(sb, ea - 38, mb - ma);
   endfunction

   function automatic logic [31:0] predict_rsqrt(logic [31:0] x);
      logic [31:0] y0, h, p, q, t, r;
      y0 = fisr_pkg::MAGIC_SEED - (x >> 1);
      h = float_mul(fisr_pkg::HALF_BITS, x);
      p = float_mul(h, y0);
      q = float_mul(p, y0);
      t = float_add(fisr_pkg::THREEHALVES, {~q[31], q[30:0]});
      r = float_mul(y0, t);
      if (f_nan(r)) r = fisr_pkg::QNAN_BITS;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch: %s got %08h expected %08h at %0t", what, got, want,
               $realtime);
      error_count++;
   endtask

   // ------------------------------------------------------------------------
   // directed words: result typed in only for the obvious cases
   // ------------------------------------------------------------------------
   stim_type directed[] = '{
      '{32'h7fc00000, 1'b1, 32'h7fc00000},  // quiet nan in
      '{32'hffffffff, 1'b1, 32'h7fc00000},  // negative nan
      '{32'h7f800001, 1'b1, 32'h7fc00000},  // signaling nan
      '{32'h7f800000, 1'b0, 32'h0},         // +inf
      '{32'hff800000, 1'b0, 32'h0},         // -inf
      '{32'h00000000, 1'b0, 32'h0},         // +0
      '{32'h80000000, 1'b0, 32'h0},         // -0
      '{32'h00000001, 1'b0, 32'h0},         // smallest subnormal
      '{32'h007fffff, 1'b0, 32'h0},         // largest subnormal
      '{32'h00800000, 1'b0, 32'h0},
      '{32'h7f7fffff, 1'b0, 32'h0},         // largest finite
      '{32'h3f800000, 1'b0, 32'h0},         // 1.0
      '{32'h40800000, 1'b0, 32'h0},         // 4.0
      '{32'h3e800000, 1'b0, 32'h0},         // 0.25
      '{32'hbf800000, 1'b0, 32'h0},         // -1.0
      '{32'h80000001, 1'b0, 32'h0},
      '{32'h807fffff, 1'b0, 32'h0},
      '{32'hff7fffff, 1'b0, 32'h0},
      '{32'h5f375a86, 1'b0, 32'h0},
      '{32'hbe6eb50c, 1'b0, 32'h0},         // seed minus half the word is exactly zero
      '{32'h55555555, 1'b0, 32'h0},
      '{32'haaaaaaaa, 1'b0, 32'h0}
   };

   function automatic logic [31:0] random_word();
      int          pick;
      logic [31:0] w;
      pick = $urandom_range(0, 9);
      w = $urandom;
      case (pick)
         0: w[30:23] = 8'd0;                          // subnormal
         1: w[30:23] = 8'hff;                         // inf / nan
         2: w[30:23] = 8'(254 - $urandom_range(0, 3));
         3: w[30:23] = 8'($urandom_range(1, 4));
         default: w[31] = ($urandom_range(0, 5) == 0);  // mostly positive
      endcase
      return w;
   endfunction

   task automatic send_word(input logic [31:0] x);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.bits <= x;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------
   initial begin
      req_ch.valid = 1'b0;
      req_ch.bits = 32'd0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) begin
         expected_words.push_back(directed[i].known ? directed[i].r
                                                    : predict_rsqrt(directed[i].x));
         send_word(directed[i].x);
         words_sent++;
      end

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 50 : 0;
         take_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 15 : 0;
         for (int n = 0; n < RANDOM_WORDS / 3; n++) begin
            logic [31:0] w;
            w = random_word();
            if (n == 100) begin
               // hold off until the pipe has emptied
               req_ch.valid <= 1'b0;
               while (expected_words.size() != 0) @(negedge clock);
            end
            expected_words.push_back(predict_rsqrt(w));
            send_word(w);
            words_sent++;
         end
      end
      req_ch.valid <= 1'b0;

      while (expected_words.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      $display("sent %0d words (specials, subnormals, extremes, random), checked %0d",
               words_sent, words_checked);
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // receiver and checker
   // ------------------------------------------------------------------------
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready <= !reset && ($urandom_range(0, 99) >= take_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected word", rsp_ch.bits, 32'd0);
         end else begin
            logic [31:0] want;
            want = expected_words.pop_front();
            if (rsp_ch.bits !== want) report_mismatch("result_bits", rsp_ch.bits, want);
            words_checked++;
         end
      end
   end

   initial begin
      #5ms;
      $display("testbench: done, errors");
      $finish;
   end

endmodule
